// ===== design/bcomp_pkg.sv =====
// Shared types and constants of the barometer compensation block.
package bcomp_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_CAL_A_FIRST = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_A_LAST  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_B_PAIR  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CAL_M_PAIR  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OVERSAMPLE  = 3'd4;

  localparam int unsigned DIV_NUM_W  = 32;
  localparam int unsigned DIV_DEN_W  = 18;
  localparam int unsigned DIV_SIDE_W = 39;

  localparam logic [15:0]        PRESS_SCALE = 16'd50000;
  localparam logic signed [27:0] B6_OFFSET   = 28'sd4000;
  localparam logic signed [14:0] P_LIN_COEF  = -15'sd7357;
  localparam logic [11:0]        P_SQ_COEF   = 12'd3038;
  localparam logic signed [44:0] P_OFFSET    = 45'sd3791;
  localparam logic signed [41:0] X4_OFFSET   = 42'sd32768;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

endpackage

// ===== design/bcomp_sample_if.sv =====
// Raw sample channel: temperature and pressure words.
interface bcomp_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [18:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

// ===== design/bcomp_result_if.sv =====
// Compensated result channel.
interface bcomp_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_deci_c;
  logic signed [31:0] pressure_pa;
  logic               divide_error;

  modport source (output valid, temperature_deci_c, pressure_pa, divide_error, input ready);
  modport sink (input valid, temperature_deci_c, pressure_pa, divide_error, output ready);
endinterface

// ===== design/bcomp_cfg_if.sv =====
// Configuration write channel.
interface bcomp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bcomp_pkg::CFG_INDEX_W-1:0] index;
  logic [bcomp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/bcomp_cfg.sv =====
// Calibration and oversampling registers.
module bcomp_cfg (
  input  logic            clk,
  input  logic            rst,
  bcomp_cfg_if.sink       cfg,
  output bcomp_pkg::cal_t cal
);
  import bcomp_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CAL_A_FIRST: begin
          cal.ac1 <= cfg.data[47:32];
          cal.ac2 <= cfg.data[31:16];
          cal.ac3 <= cfg.data[15:0];
        end
        REG_CAL_A_LAST: begin
          cal.ac4 <= cfg.data[47:32];
          cal.ac5 <= cfg.data[31:16];
          cal.ac6 <= cfg.data[15:0];
        end
        REG_CAL_B_PAIR: begin
          cal.b1 <= cfg.data[31:16];
          cal.b2 <= cfg.data[15:0];
        end
        REG_CAL_M_PAIR: begin
          cal.mc <= cfg.data[31:16];
          cal.md <= cfg.data[15:0];
        end
        REG_OVERSAMPLE: begin
          cal.oss <= cfg.data[1:0];
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== design/bcomp_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
module bcomp_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [bcomp_pkg::DIV_NUM_W-1:0]  in_num,
  input  logic [bcomp_pkg::DIV_DEN_W-1:0]  in_den,
  input  logic [bcomp_pkg::DIV_SIDE_W-1:0] in_side,
  output logic                             out_valid,
  output logic [bcomp_pkg::DIV_NUM_W-1:0]  out_quot,
  output logic [bcomp_pkg::DIV_SIDE_W-1:0] out_side
);
  import bcomp_pkg::*;

  logic                  vld  [DIV_NUM_W+1];
  logic [DIV_NUM_W-1:0]  num  [DIV_NUM_W+1];
  logic [DIV_DEN_W-1:0]  den  [DIV_NUM_W+1];
  logic [DIV_DEN_W-1:0]  rem  [DIV_NUM_W+1];
  logic [DIV_SIDE_W-1:0] side [DIV_NUM_W+1];

  assign vld[0]  = in_valid;
  assign num[0]  = in_num;
  assign den[0]  = in_den;
  assign rem[0]  = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < DIV_NUM_W; k++) begin : g_stage
    logic [DIV_DEN_W:0] trial;
    logic [DIV_DEN_W:0] rem_next;
    logic               bit_q;

    always_comb begin
      trial    = {rem[k], num[k][DIV_NUM_W-1]};
      bit_q    = (trial >= {1'b0, den[k]});
      rem_next = bit_q ? (trial - {1'b0, den[k]}) : trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[k+1]  <= {num[k][DIV_NUM_W-2:0], bit_q};
        rem[k+1]  <= rem_next[DIV_DEN_W-1:0];
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[DIV_NUM_W];
  assign out_quot  = num[DIV_NUM_W];
  assign out_side  = side[DIV_NUM_W];
endmodule

// ===== design/barometer_compensation.sv =====
// Top level of the barometer compensation pipeline.
// Takes one raw temperature and pressure word per cycle and returns one compensated
// result per word, in order. It is built from two 32-stage divider pipelines
// (temperature term X2, pressure term p) plus 18 arithmetic and output stages. The
// whole pipeline advances whenever the output register is empty or being taken, so
// a new word is accepted every cycle while the result side keeps up. A zero divisor
// raises divide_error and forces both results to zero. Write calibration only while
// no word is in flight.
module barometer_compensation (
  input  logic           clk,
  input  logic           rst,
  bcomp_cfg_if.sink      cfg,
  bcomp_sample_if.sink   samples,
  bcomp_result_if.source results
);
  import bcomp_pkg::*;

  cal_t cal;
  logic en;

  bcomp_cfg u_cfg (.clk(clk), .rst(rst), .cfg(cfg), .cal(cal));

  assign en            = !results.valid || results.ready;
  assign samples.ready = en;

  // stage 1: (UT - AC6) * AC5
  logic signed [16:0] s0_diff;
  logic signed [16:0] s0_ac5;
  logic signed [33:0] s0_prod;
  assign s0_diff = $signed({1'b0, samples.raw_temperature}) - $signed({1'b0, cal.ac6});
  assign s0_ac5  = $signed({1'b0, cal.ac5});
  assign s0_prod = s0_diff * s0_ac5;

  logic               s1_valid;
  logic signed [33:0] s1_prod;
  logic [18:0]        s1_up;

  // stage 2: X1 and divisor X1 + MD
  logic signed [33:0] s1_sum;
  logic signed [33:0] s1_shift;
  logic signed [17:0] s1_x1;
  logic signed [18:0] s1_d1;
  assign s1_sum   = s1_prod + $signed({19'b0, {15{s1_prod[33]}}});
  assign s1_shift = s1_sum >>> 15;
  assign s1_x1    = 18'(s1_shift);
  assign s1_d1    = 19'(s1_x1) + 19'($signed(cal.md));

  logic               s2_valid;
  logic signed [17:0] s2_x1;
  logic signed [18:0] s2_d1;
  logic [18:0]        s2_up;
  logic               s2_err;

  // divider A: MC * 2048 / (X1 + MD)
  logic [15:0]            da_mc_mag;
  logic [18:0]            da_d1_mag;
  logic                   da_neg;
  logic [DIV_NUM_W-1:0]   da_num;
  logic [DIV_SIDE_W-1:0]  da_side_in;
  logic                   da_valid;
  logic [DIV_NUM_W-1:0]   da_quot;
  logic [DIV_SIDE_W-1:0]  da_side;
  assign da_mc_mag  = cal.mc[15] ? (~cal.mc + 16'd1) : cal.mc;
  assign da_d1_mag  = s2_d1[18] ? 19'(-s2_d1) : 19'(s2_d1);
  assign da_neg     = cal.mc[15] ^ s2_d1[18];
  assign da_num     = {5'b0, da_mc_mag, 11'b0};
  assign da_side_in = {s2_x1, s2_up, s2_err, da_neg};

  bcomp_div u_div_t (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s2_valid), .in_num(da_num), .in_den(da_d1_mag[DIV_DEN_W-1:0]),
    .in_side(da_side_in),
    .out_valid(da_valid), .out_quot(da_quot), .out_side(da_side)
  );

  // stage 3: B5 = X1 + X2
  logic signed [27:0] s2q_x2;
  logic signed [27:0] s2q_b5;
  assign s2q_x2 = da_side[0] ? -$signed({1'b0, da_quot[26:0]}) : $signed({1'b0, da_quot[26:0]});
  assign s2q_b5 = 28'($signed(da_side[38:21])) + s2q_x2;

  logic               s3_valid;
  logic signed [27:0] s3_b5;
  logic [18:0]        s3_up;
  logic               s3_err;

  // stage 4: temperature and B6
  logic signed [28:0] s3_y;
  logic signed [28:0] s3_ysum;
  logic signed [28:0] s3_tq;
  logic signed [15:0] s3_t;
  assign s3_y    = 29'(s3_b5) + 29'sd8;
  assign s3_ysum = s3_y + $signed({25'b0, {4{s3_y[28]}}});
  assign s3_tq   = s3_ysum >>> 4;
  always_comb begin
    if (s3_tq > 29'sd32767) begin
      s3_t = 16'sh7fff;
    end else if (s3_tq < -29'sd32768) begin
      s3_t = -16'sh8000;
    end else begin
      s3_t = 16'(s3_tq);
    end
  end

  logic               s4_valid;
  logic signed [15:0] s4_t;
  logic signed [27:0] s4_b6;
  logic [18:0]        s4_up;
  logic               s4_err;

  // stage 5: B6 squared / 4096
  logic signed [55:0] s4_sqp;
  assign s4_sqp = s4_b6 * s4_b6;

  logic               s5_valid;
  logic [41:0]        s5_sq;
  logic signed [15:0] s5_t;
  logic signed [27:0] s5_b6;
  logic [18:0]        s5_up;
  logic               s5_err;

  // stage 6: partial products
  logic signed [21:0] s5_sq_lo;
  logic signed [21:0] s5_sq_hi;
  logic signed [37:0] s5_b2lo;
  logic signed [37:0] s5_b2hi;
  logic signed [37:0] s5_b1lo;
  logic signed [37:0] s5_b1hi;
  logic signed [43:0] s5_mac2;
  logic signed [43:0] s5_mac3;
  assign s5_sq_lo = $signed({1'b0, s5_sq[20:0]});
  assign s5_sq_hi = $signed({1'b0, s5_sq[41:21]});
  assign s5_b2lo  = $signed(cal.b2) * s5_sq_lo;
  assign s5_b2hi  = $signed(cal.b2) * s5_sq_hi;
  assign s5_b1lo  = $signed(cal.b1) * s5_sq_lo;
  assign s5_b1hi  = $signed(cal.b1) * s5_sq_hi;
  assign s5_mac2  = $signed(cal.ac2) * s5_b6;
  assign s5_mac3  = $signed(cal.ac3) * s5_b6;

  logic               s6_valid;
  logic signed [37:0] s6_b2lo;
  logic signed [37:0] s6_b2hi;
  logic signed [37:0] s6_b1lo;
  logic signed [37:0] s6_b1hi;
  logic signed [43:0] s6_mac2;
  logic signed [43:0] s6_mac3;
  logic signed [15:0] s6_t;
  logic [18:0]        s6_up;
  logic               s6_err;

  // stage 7: join partial products
  logic signed [57:0] s6_cb2;
  logic signed [57:0] s6_cb1;
  assign s6_cb2 = (58'(s6_b2hi) <<< 21) + 58'(s6_b2lo);
  assign s6_cb1 = (58'(s6_b1hi) <<< 21) + 58'(s6_b1lo);

  logic               s7_valid;
  logic signed [57:0] s7_cb2;
  logic signed [57:0] s7_cb1;
  logic signed [43:0] s7_mac2;
  logic signed [43:0] s7_mac3;
  logic signed [15:0] s7_t;
  logic [18:0]        s7_up;
  logic               s7_err;

  // stage 8: truncating scales
  logic signed [57:0] s7_cb2s;
  logic signed [57:0] s7_cb1s;
  logic signed [43:0] s7_mac2s;
  logic signed [43:0] s7_mac3s;
  logic signed [57:0] s7_cb2q;
  logic signed [57:0] s7_cb1q;
  logic signed [43:0] s7_mac2q;
  logic signed [43:0] s7_mac3q;
  assign s7_cb2s  = s7_cb2 + $signed({47'b0, {11{s7_cb2[57]}}});
  assign s7_cb1s  = s7_cb1 + $signed({42'b0, {16{s7_cb1[57]}}});
  assign s7_mac2s = s7_mac2 + $signed({33'b0, {11{s7_mac2[43]}}});
  assign s7_mac3s = s7_mac3 + $signed({31'b0, {13{s7_mac3[43]}}});
  assign s7_cb2q  = s7_cb2s >>> 11;
  assign s7_cb1q  = s7_cb1s >>> 16;
  assign s7_mac2q = s7_mac2s >>> 11;
  assign s7_mac3q = s7_mac3s >>> 13;

  logic               s8_valid;
  logic signed [46:0] s8_x1;
  logic signed [32:0] s8_x2;
  logic signed [30:0] s8_x1b;
  logic signed [41:0] s8_x2b;
  logic signed [15:0] s8_t;
  logic [18:0]        s8_up;
  logic               s8_err;

  logic               s9_valid;
  logic signed [47:0] s9_x3;
  logic signed [42:0] s9_yb;
  logic signed [15:0] s9_t;
  logic [18:0]        s9_up;
  logic               s9_err;

  // stage 10: B3 numerator and B4 operand
  logic signed [17:0] s9_ac1x4;
  logic signed [48:0] s9_sum;
  logic signed [51:0] s9_shl;
  logic signed [52:0] s9_pre;
  logic signed [42:0] s9_ybs;
  logic signed [42:0] s9_ybq;
  logic signed [41:0] s9_x4;
  assign s9_ac1x4 = $signed({cal.ac1, 2'b00});
  assign s9_sum   = 49'(s9_ac1x4) + 49'(s9_x3);
  assign s9_shl   = 52'(s9_sum) <<< cal.oss;
  assign s9_pre   = 53'(s9_shl) + 53'sd2;
  assign s9_ybs   = s9_yb + $signed({41'b0, {2{s9_yb[42]}}});
  assign s9_ybq   = s9_ybs >>> 2;
  assign s9_x4    = 42'(s9_ybq) + X4_OFFSET;

  logic               s10_valid;
  logic signed [52:0] s10_pre;
  logic [31:0]        s10_u;
  logic signed [15:0] s10_t;
  logic [18:0]        s10_up;
  logic               s10_err;

  // stage 11: B3 and AC4 product
  logic signed [52:0] s10_psum;
  logic [47:0]        s10_b4m;
  assign s10_psum = s10_pre + $signed({51'b0, {2{s10_pre[52]}}});
  assign s10_b4m  = cal.ac4 * s10_u;

  logic               s11_valid;
  logic [31:0]        s11_b3;
  logic [31:0]        s11_b4p;
  logic signed [15:0] s11_t;
  logic [18:0]        s11_up;
  logic               s11_err;

  // stage 12: B7 and B4
  logic [31:0] s11_b7p;
  logic [15:0] s11_fac;
  logic [47:0] s11_b7m;
  logic [16:0] s11_b4;
  assign s11_b7p = {13'b0, s11_up} - s11_b3;
  assign s11_fac = PRESS_SCALE >> cal.oss;
  assign s11_b7m = s11_b7p * s11_fac;
  assign s11_b4  = s11_b4p[31:15];

  logic               s12_valid;
  logic [31:0]        s12_b7;
  logic [16:0]        s12_b4;
  logic signed [15:0] s12_t;
  logic               s12_err;

  // divider B: B7 / B4
  logic                  db_dbl;
  logic [DIV_NUM_W-1:0]  db_num;
  logic [DIV_SIDE_W-1:0] db_side_in;
  logic                  db_valid;
  logic [DIV_NUM_W-1:0]  db_quot;
  logic [DIV_SIDE_W-1:0] db_side;
  assign db_dbl     = s12_b7[31];
  assign db_num     = db_dbl ? s12_b7 : {s12_b7[30:0], 1'b0};
  assign db_side_in = {21'b0, s12_t, s12_err, db_dbl};

  bcomp_div u_div_p (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s12_valid), .in_num(db_num), .in_den({1'b0, s12_b4}),
    .in_side(db_side_in),
    .out_valid(db_valid), .out_quot(db_quot), .out_side(db_side)
  );

  logic               s13_valid;
  logic signed [31:0] s13_ps;
  logic signed [15:0] s13_t;
  logic               s13_err;

  // stage 14: p / 256 and linear term
  logic signed [31:0] s13_pss;
  logic signed [31:0] s13_psq;
  logic signed [46:0] s13_m7;
  assign s13_pss = s13_ps + $signed({24'b0, {8{s13_ps[31]}}});
  assign s13_psq = s13_pss >>> 8;
  assign s13_m7  = s13_ps * P_LIN_COEF;

  logic               s14_valid;
  logic signed [23:0] s14_a;
  logic signed [46:0] s14_m7;
  logic signed [31:0] s14_ps;
  logic signed [15:0] s14_t;
  logic               s14_err;

  logic signed [47:0] s14_sqa;
  logic signed [46:0] s14_m7s;
  logic signed [46:0] s14_m7q;
  assign s14_sqa = s14_a * s14_a;
  assign s14_m7s = s14_m7 + $signed({31'b0, {16{s14_m7[46]}}});
  assign s14_m7q = s14_m7s >>> 16;

  logic               s15_valid;
  logic [46:0]        s15_sqa;
  logic signed [30:0] s15_x2;
  logic signed [31:0] s15_ps;
  logic signed [15:0] s15_t;
  logic               s15_err;

  logic [58:0] s15_pm;
  assign s15_pm = s15_sqa * P_SQ_COEF;

  logic               s16_valid;
  logic [58:0]        s16_pm;
  logic signed [30:0] s16_x2;
  logic signed [31:0] s16_ps;
  logic signed [15:0] s16_t;
  logic               s16_err;

  logic signed [44:0] s16_s;
  assign s16_s = 45'($signed({1'b0, s16_pm[58:16]})) + 45'(s16_x2) + P_OFFSET;

  logic               s17_valid;
  logic signed [44:0] s17_s;
  logic signed [31:0] s17_ps;
  logic signed [15:0] s17_t;
  logic               s17_err;

  logic signed [44:0] s17_ss;
  logic signed [44:0] s17_sq;
  logic [31:0]        s17_pf;
  assign s17_ss = s17_s + $signed({41'b0, {4{s17_s[44]}}});
  assign s17_sq = s17_ss >>> 4;
  assign s17_pf = s17_ps + s17_sq[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      s9_valid <= 1'b0;
      s10_valid <= 1'b0;
      s11_valid <= 1'b0;
      s12_valid <= 1'b0;
      s13_valid <= 1'b0;
      s14_valid <= 1'b0;
      s15_valid <= 1'b0;
      s16_valid <= 1'b0;
      s17_valid <= 1'b0;
      results.valid <= 1'b0;
    end else if (en) begin
      s1_valid <= samples.valid;
      s2_valid <= s1_valid;
      s3_valid <= da_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
      s9_valid <= s8_valid;
      s10_valid <= s9_valid;
      s11_valid <= s10_valid;
      s12_valid <= s11_valid;
      s13_valid <= db_valid;
      s14_valid <= s13_valid;
      s15_valid <= s14_valid;
      s16_valid <= s15_valid;
      s17_valid <= s16_valid;
      results.valid <= s17_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= s0_prod;
      s1_up   <= samples.raw_pressure;

      s2_x1  <= s1_x1;
      s2_d1  <= s1_d1;
      s2_up  <= s1_up;
      s2_err <= (s1_d1 == 19'sd0);

      s3_b5  <= s2q_b5;
      s3_up  <= da_side[20:2];
      s3_err <= da_side[1];

      s4_t   <= s3_t;
      s4_b6  <= s3_b5 - B6_OFFSET;
      s4_up  <= s3_up;
      s4_err <= s3_err;

      s5_sq  <= 42'(s4_sqp[53:12]);
      s5_t   <= s4_t;
      s5_b6  <= s4_b6;
      s5_up  <= s4_up;
      s5_err <= s4_err;

      s6_b2lo <= s5_b2lo;
      s6_b2hi <= s5_b2hi;
      s6_b1lo <= s5_b1lo;
      s6_b1hi <= s5_b1hi;
      s6_mac2 <= s5_mac2;
      s6_mac3 <= s5_mac3;
      s6_t    <= s5_t;
      s6_up   <= s5_up;
      s6_err  <= s5_err;

      s7_cb2  <= s6_cb2;
      s7_cb1  <= s6_cb1;
      s7_mac2 <= s6_mac2;
      s7_mac3 <= s6_mac3;
      s7_t    <= s6_t;
      s7_up   <= s6_up;
      s7_err  <= s6_err;

      s8_x1  <= 47'(s7_cb2q);
      s8_x2  <= 33'(s7_mac2q);
      s8_x1b <= 31'(s7_mac3q);
      s8_x2b <= 42'(s7_cb1q);
      s8_t   <= s7_t;
      s8_up  <= s7_up;
      s8_err <= s7_err;

      s9_x3  <= 48'(s8_x1) + 48'(s8_x2);
      s9_yb  <= 43'(s8_x1b) + 43'(s8_x2b) + 43'sd2;
      s9_t   <= s8_t;
      s9_up  <= s8_up;
      s9_err <= s8_err;

      s10_pre <= s9_pre;
      s10_u   <= s9_x4[31:0];
      s10_t   <= s9_t;
      s10_up  <= s9_up;
      s10_err <= s9_err;

      s11_b3  <= s10_psum[33:2];
      s11_b4p <= s10_b4m[31:0];
      s11_t   <= s10_t;
      s11_up  <= s10_up;
      s11_err <= s10_err;

      s12_b7  <= s11_b7m[31:0];
      s12_b4  <= s11_b4;
      s12_t   <= s11_t;
      s12_err <= s11_err || (s11_b4 == 17'd0);

      s13_ps  <= db_side[0] ? $signed({db_quot[30:0], 1'b0}) : $signed(db_quot);
      s13_t   <= $signed(db_side[17:2]);
      s13_err <= db_side[1];

      s14_a   <= 24'(s13_psq);
      s14_m7  <= s13_m7;
      s14_ps  <= s13_ps;
      s14_t   <= s13_t;
      s14_err <= s13_err;

      s15_sqa <= s14_sqa[46:0];
      s15_x2  <= 31'(s14_m7q);
      s15_ps  <= s14_ps;
      s15_t   <= s14_t;
      s15_err <= s14_err;

      s16_pm  <= s15_pm;
      s16_x2  <= s15_x2;
      s16_ps  <= s15_ps;
      s16_t   <= s15_t;
      s16_err <= s15_err;

      s17_s   <= s16_s;
      s17_ps  <= s16_ps;
      s17_t   <= s16_t;
      s17_err <= s16_err;

      results.temperature_deci_c <= s17_err ? 16'sd0 : s17_t;
      results.pressure_pa        <= s17_err ? 32'sd0 : $signed(s17_pf);
      results.divide_error       <= s17_err;
    end
  end
endmodule

// ===== verif/tb_barometer_compensation.sv =====
// Testbench for barometer_compensation: directed table plus random words, checked in order.
`timescale 1ns / 100ps

module tb_barometer_compensation;
  import bcomp_pkg::*;

  localparam int           LATENCY     = 82;
  localparam longint       CYCLE_LIMIT = 600000;
  localparam longint unsigned MASK32   = 64'hFFFF_FFFF;

  typedef struct {
    logic signed [15:0] temperature_deci_c;
    logic signed [31:0] pressure_pa;
    logic               divide_error;
  } reading_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  index;
    logic [47:0] data;
    logic [15:0] ut;
    logic [18:0] up;
    bit          typed;
    reading_t    want;
  } stim_row_t;

  logic clk;
  logic rst;

  bcomp_cfg_if    cfg ();
  bcomp_sample_if samples ();
  bcomp_result_if results ();

  barometer_compensation dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg.sink),
    .samples (samples.sink),
    .results (results.source)
  );

  logic [47:0] cal_first;
  logic [47:0] cal_last;
  logic [31:0] cal_b;
  logic [31:0] cal_m;
  logic [1:0]  oss_reg;

  reading_t    pending_readings[$];
  stim_row_t   directed[$];
  int          error_count;
  int          stall_pct;
  longint      cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic reading_t compensate(input logic [15:0] ut_w, input logic [18:0] up_w);
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint ut, x1, x2, x3, b5, b6, b3, t, sq, ps, pf;
    longint unsigned up, b4, b7, p32;
    int oss;
    reading_t r;
    ac1 = longint'($signed(cal_first[47:32]));
    ac2 = longint'($signed(cal_first[31:16]));
    ac3 = longint'($signed(cal_first[15:0]));
    ac4 = longint'(cal_last[47:32]);
    ac5 = longint'(cal_last[31:16]);
    ac6 = longint'(cal_last[15:0]);
    b1  = longint'($signed(cal_b[31:16]));
    b2  = longint'($signed(cal_b[15:0]));
    mc  = longint'($signed(cal_m[31:16]));
    md  = longint'($signed(cal_m[15:0]));
    oss = oss_reg;
    ut  = longint'(ut_w);
    up  = longint'(up_w);
    r.temperature_deci_c = '0;
    r.pressure_pa        = '0;
    r.divide_error       = 1'b1;
    x1 = (ut - ac6) * ac5 / 32768;
    if (x1 + md == 0) return r;
    x2 = (mc * 2048) / (x1 + md);
    b5 = x1 + x2;
    t  = (b5 + 8) / 16;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    b6 = b5 - 4000;
    sq = (b6 * b6) / 4096;
    x1 = (b2 * sq) / 2048;
    x2 = (ac2 * b6) / 2048;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
    x1 = (ac3 * b6) / 8192;
    x2 = (b1 * sq) / 65536;
    x3 = ((x1 + x2) + 2) / 4;
    b4 = ((longint'(ac4) * (longint'(x3 + 32768) & MASK32)) & MASK32) / 32768;
    if (b4 == 0) return r;
    b7 = ((up - longint'(b3)) * longint'(50000 >> oss)) & MASK32;
    if (b7 < 64'h8000_0000) p32 = ((b7 * 2) / b4) & MASK32;
    else p32 = ((b7 / b4) * 2) & MASK32;
    ps = p32[31] ? longint'(p32) - 64'sh1_0000_0000 : longint'(p32);
    x1 = (ps / 256) * (ps / 256);
    x1 = (x1 * 3038) / 65536;
    x2 = (-7357 * ps) / 65536;
    pf = ps + (x1 + x2 + 3791) / 16;
    r.temperature_deci_c = t[15:0];
    r.pressure_pa        = pf[31:0];
    r.divide_error       = 1'b0;
    return r;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    samples.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [47:0] data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    case (index)
      REG_CAL_A_FIRST: cal_first = data;
      REG_CAL_A_LAST:  cal_last  = data;
      REG_CAL_B_PAIR:  cal_b     = data[31:0];
      REG_CAL_M_PAIR:  cal_m     = data[31:0];
      REG_OVERSAMPLE:  oss_reg   = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_word(input logic [15:0] ut, input logic [18:0] up, input bit typed,
                           input reading_t want);
    @(negedge clk);
    samples.valid           <= 1'b1;
    samples.raw_temperature <= ut;
    samples.raw_pressure    <= up;
    do @(posedge clk); while (!samples.ready);
    pending_readings.push_back(typed ? want : compensate(ut, up));
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    samples.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic void add_sample(input logic [15:0] ut, input logic [18:0] up,
                                     input bit typed);
    stim_row_t row;
    row.kind  = ROW_SAMPLE;
    row.index = '0;
    row.data  = '0;
    row.ut    = ut;
    row.up    = up;
    row.typed = typed;
    row.want  = '{temperature_deci_c: '0, pressure_pa: '0, divide_error: 1'b1};
    directed.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [2:0] index, input logic [47:0] data);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.index = index;
    row.data  = data;
    row.ut    = '0;
    row.up    = '0;
    row.typed = 1'b0;
    row.want  = '{temperature_deci_c: '0, pressure_pa: '0, divide_error: 1'b0};
    directed.push_back(row);
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  always @(negedge clk) begin
    if (cycle_count[9:8] == 2'd0) results.ready <= 1'b1;
    else results.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    reading_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst && results.valid && results.ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected word T=%0d P=%0d err=%0b", $time,
                 results.temperature_deci_c, results.pressure_pa, results.divide_error);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        if (results.temperature_deci_c !== want.temperature_deci_c) begin
          $display("%0t: temperature_deci_c expected %0d actual %0d", $time,
                   want.temperature_deci_c, results.temperature_deci_c);
          error_count++;
        end
        if (results.pressure_pa !== want.pressure_pa) begin
          $display("%0t: pressure_pa expected %0d actual %0d", $time,
                   want.pressure_pa, results.pressure_pa);
          error_count++;
        end
        if (results.divide_error !== want.divide_error) begin
          $display("%0t: divide_error expected %0b actual %0b", $time,
                   want.divide_error, results.divide_error);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [15:0] ut;
    logic [18:0] up;
    logic [47:0] v;
    int burst;
    int mode;
    reading_t none;
    none = '{temperature_deci_c: '0, pressure_pa: '0, divide_error: 1'b0};
    error_count = 0;
    cycle_count = 0;
    stall_pct   = 30;
    cal_first = '0;
    cal_last  = '0;
    cal_b     = '0;
    cal_m     = '0;
    oss_reg   = '0;
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    samples.valid           = 1'b0;
    samples.raw_temperature = '0;
    samples.raw_pressure    = '0;
    results.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_sample(16'd0, 19'd0, 1'b1);
    add_sample(16'hFFFF, 19'h7FFFF, 1'b1);
    add_cfg(3'd5, 48'hFFFF_FFFF_FFFF);
    add_cfg(REG_CAL_A_FIRST, {16'd408, 16'hFFB8, 16'hC7D1});
    add_cfg(REG_CAL_A_LAST, {16'h7FE5, 16'h7FF5, 16'h5A71});
    add_cfg(REG_CAL_B_PAIR, {16'h182E, 16'h0004});
    add_cfg(REG_CAL_M_PAIR, {16'hDDF9, 16'h0B34});
    add_cfg(REG_OVERSAMPLE, 48'd0);
    add_sample(16'd27898, 19'd23843, 1'b0);
    add_sample(16'd0, 19'd0, 1'b0);
    add_sample(16'hFFFF, 19'h7FFFF, 1'b0);
    add_sample(16'd0, 19'h7FFFF, 1'b0);
    add_sample(16'hFFFF, 19'd0, 1'b0);
    add_cfg(REG_OVERSAMPLE, 48'd3);
    add_sample(16'd27898, 19'd190744, 1'b0);
    add_sample(16'hFFFF, 19'h7FFFF, 1'b0);
    add_cfg(REG_CAL_A_LAST, {16'h0000, 16'h7FF5, 16'h5A71});
    add_sample(16'd23153, 19'd1000, 1'b1);
    add_cfg(REG_CAL_A_LAST, {16'h7FE5, 16'h0000, 16'h5A71});
    add_cfg(REG_CAL_M_PAIR, {16'hDDF9, 16'h0000});
    add_sample(16'd12345, 19'd777, 1'b1);
    add_cfg(REG_CAL_A_FIRST, 48'hFFFF_FFFF_FFFF);
    add_cfg(REG_CAL_A_LAST, 48'hFFFF_FFFF_FFFF);
    add_cfg(REG_CAL_B_PAIR, 48'hFFFF_FFFF);
    add_cfg(REG_CAL_M_PAIR, 48'hFFFF_FFFF);
    add_sample(16'd0, 19'd0, 1'b0);
    add_sample(16'hFFFF, 19'h7FFFF, 1'b0);
    add_cfg(REG_CAL_A_FIRST, {16'h7FFF, 16'h8000, 16'h7FFF});
    add_cfg(REG_CAL_B_PAIR, {16'h7FFF, 16'h7FFF});
    add_cfg(REG_CAL_M_PAIR, {16'h8000, 16'h7FFF});
    add_sample(16'h8000, 19'h40000, 1'b0);
    add_sample(16'h5555, 19'h2AAAA, 1'b0);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed[i].index, directed[i].data);
      end else begin
        send_word(directed[i].ut, directed[i].up, directed[i].typed, directed[i].want);
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      stall_pct = $urandom_range(0, 70);
      mode = (phase < 2) ? 2 : $urandom_range(0, 2);
      for (int r = 0; r < 5; r++) begin
        case (mode)
          0: v = rand48();
          1: v = $urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : 48'h0;
          default: begin
            case (r)
              0: v = {16'($urandom_range(0, 1200)) - 16'd600,
                      16'($urandom_range(0, 400)) - 16'd200,
                      16'($urandom_range(0, 30000)) - 16'd15000};
              1: v = {16'($urandom_range(20000, 40000)), 16'($urandom_range(20000, 40000)),
                      16'($urandom_range(15000, 30000))};
              2: v = {16'($urandom_range(4000, 8000)), 16'($urandom_range(0, 100))};
              3: v = {16'(-$urandom_range(7000, 12000)), 16'($urandom_range(1500, 4000))};
              default: v = 48'(phase % 4);
            endcase
          end
        endcase
        if (r == 4 && phase < 4) v = 48'(phase);
        write_reg(3'(r), v);
      end
      if ($urandom_range(0, 2) == 0) write_reg(3'($urandom_range(5, 7)), rand48());
      for (int n = 0; n < 88; ) begin
        burst = $urandom_range(1, 16);
        for (int b = 0; b < burst && n < 88; b++, n++) begin
          case ($urandom_range(0, 9))
            0: begin ut = 16'hFFFF; up = 19'h7FFFF; end
            1: begin ut = 16'h0; up = 19'h0; end
            2, 3, 4: begin
              ut = 16'($urandom_range(20000, 34000));
              up = 19'($urandom_range(15000, 45000)) << oss_reg;
            end
            default: begin ut = 16'($urandom); up = 19'($urandom); end
          endcase
          send_word(ut, up, 1'b0, none);
          if (phase == 3 && n == 40) begin
            samples.valid <= samples.valid;
            hold_off(1);
            while (pending_readings.size() != 0) @(negedge clk);
          end
        end
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
      end
    end

    hold_off(1);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== barometer_compensation.f =====
design/bcomp_pkg.sv
design/bcomp_sample_if.sv
design/bcomp_result_if.sv
design/bcomp_cfg_if.sv
design/bcomp_cfg.sv
design/bcomp_div.sv
design/barometer_compensation.sv
verif/tb_barometer_compensation.sv
